FILE: src/tlaik_pkg.sv
// Shared types, widths and constants for the two-link arm inverse kinematics block.
// No dependencies; every other file imports it.
package tlaik_pkg;

    localparam int DATA_WIDTH_DEF = 16;

    localparam int COORD_W = 16;
    localparam int LEN_W   = 15;
    localparam int ANG_W   = 16;
    localparam int ELB_W   = 14;
    localparam int IDX_W   = 2;

    localparam int DIV_W      = 31;
    localparam int DIV_STEPS  = DIV_W;
    localparam int SQRT_W     = 31;
    localparam int SQRT_STEPS = SQRT_W;
    localparam int RAD_W      = 2 * SQRT_W;
    localparam int REM_W      = SQRT_W + 2;

    localparam int CORDIC_STEPS = 17;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
    localparam int Z_W          = 20;
    localparam int LINK_W       = 50;
    localparam int TGT_W        = 48;
    localparam int ELB_CW       = 34;

    localparam logic signed [Z_W-1:0] PI_Q16 = 20'sd205887;
    localparam logic signed [Z_W-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
        20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
        20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
        20'sd8, 20'sd4, 20'sd2, 20'sd1
    };

    localparam logic [ELB_W-1:0] ELBOW_MAX = 14'd12868;
    localparam logic [LEN_W-1:0] L1_RESET  = 15'd8192;
    localparam logic [LEN_W-1:0] L2_RESET  = 15'd6144;

    localparam logic [IDX_W-1:0] REG_UPPER_LINK = 2'd0;
    localparam logic [IDX_W-1:0] REG_LOWER_LINK = 2'd1;

    typedef struct packed {
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
    } t_ik_in;

    typedef struct packed {
        logic signed [ANG_W-1:0] shoulder_angle;
        logic [ELB_W-1:0]        elbow_angle;
        logic                    out_of_reach;
    } t_ik_out;

    typedef struct packed {
        logic                      neg;
        logic                      flag;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_div_sb;

    typedef struct packed {
        logic                      flag;
        logic signed [31:0]        c2;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_sqrt_sb;

endpackage

FILE: src/tlaik_div.sv
// Pipelined restoring divider: rounded Q30 ratio mag/den, one quotient bit per stage.
// Depends on tlaik_pkg.
module tlaik_div import tlaik_pkg::*; #(
    parameter int SB_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DIV_W-1:0]  i_mag,
    input  logic [DIV_W-1:0]  i_den,
    input  logic [SB_W-1:0]   i_sb,
    output logic              o_valid,
    output logic [DIV_W-1:0]  o_quo,
    output logic [SB_W-1:0]   o_sb
);

    logic [2*DIV_W-1:0] dvd;
    logic [DIV_W-1:0]   r_rem [DIV_STEPS];
    logic [DIV_W-1:0]   r_low [DIV_STEPS];
    logic [DIV_W-1:0]   r_den [DIV_STEPS];
    logic [DIV_W-1:0]   r_q   [DIV_STEPS+1];
    logic [SB_W-1:0]    r_sb  [DIV_STEPS+1];
    logic               r_v   [DIV_STEPS+1];

    // mag * 2^30 + floor(den / 2)
    assign dvd = {1'b0, i_mag, {(DIV_W-1){1'b0}}}
               + {{(DIV_W+1){1'b0}}, i_den[DIV_W-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= dvd[2*DIV_W-1:DIV_W];
            r_low[0] <= dvd[DIV_W-1:0];
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_sb[0]  <= i_sb;
        end
    end

    for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
        logic [DIV_W:0]   t;
        logic [DIV_W+1:0] d;
        logic             ge;

        assign t  = {r_rem[s-1], r_low[s-1][DIV_STEPS-s]};
        assign d  = {1'b0, t} - {2'b00, r_den[s-1]};
        assign ge = !d[DIV_W+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s]  <= {r_q[s-1][DIV_W-2:0], ge};
                r_sb[s] <= r_sb[s-1];
            end
        end

        if (s < DIV_STEPS) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= ge ? d[DIV_W-1:0] : t[DIV_W-1:0];
                    r_low[s] <= r_low[s-1];
                    r_den[s] <= r_den[s-1];
                end
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS];
    assign o_quo   = r_q[DIV_STEPS];
    assign o_sb    = r_sb[DIV_STEPS];

endmodule

FILE: src/tlaik_sqrt.sv
// Pipelined integer square root, one root bit per stage (floor result).
// Depends on tlaik_pkg.
module tlaik_sqrt import tlaik_pkg::*; #(
    parameter int SB_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RAD_W-1:0]  i_rad,
    input  logic [SB_W-1:0]   i_sb,
    output logic              o_valid,
    output logic [SQRT_W-1:0] o_root,
    output logic [SB_W-1:0]   o_sb
);

    logic [RAD_W-1:0]  r_rad  [SQRT_STEPS];
    logic [REM_W-1:0]  r_rem  [SQRT_STEPS];
    logic [SQRT_W-1:0] r_root [SQRT_STEPS+1];
    logic [SB_W-1:0]   r_sb   [SQRT_STEPS+1];
    logic              r_v    [SQRT_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_sb[0]   <= i_sb;
        end
    end

    for (genvar s = 1; s <= SQRT_STEPS; s++) begin : g_step
        logic [REM_W+1:0] t;
        logic [REM_W+1:0] trial;
        logic [REM_W+2:0] d;
        logic             ge;

        assign t     = {r_rem[s-1], r_rad[s-1][2*(SQRT_STEPS-s)+1 -: 2]};
        assign trial = {2'b00, r_root[s-1], 2'b01};
        assign d     = {1'b0, t} - {1'b0, trial};
        assign ge    = !d[REM_W+2];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[s] <= {r_root[s-1][SQRT_W-2:0], ge};
                r_sb[s]   <= r_sb[s-1];
            end
        end

        if (s < SQRT_STEPS) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= ge ? d[REM_W-1:0] : t[REM_W-1:0];
                    r_rad[s] <= r_rad[s-1];
                end
            end
        end
    end

    assign o_valid = r_v[SQRT_STEPS];
    assign o_root  = r_root[SQRT_STEPS];
    assign o_sb    = r_sb[SQRT_STEPS];

endmodule

FILE: src/tlaik_cordic.sv
// Pipelined vectoring CORDIC atan2 with half-plane fold, Q16 angle out.
// Depends on tlaik_pkg.
module tlaik_cordic import tlaik_pkg::*; #(
    parameter int W = ELB_CW
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [W-1:0]   i_x,
    input  logic signed [W-1:0]   i_y,
    output logic signed [Z_W-1:0] o_z
);

    logic                  fold;
    logic signed [W-1:0]   x0;
    logic signed [W-1:0]   y0;
    logic signed [W-1:0]   r_x    [CORDIC_STEPS];
    logic signed [W-1:0]   r_y    [CORDIC_STEPS];
    logic                  r_zero [CORDIC_STEPS];
    logic signed [Z_W-1:0] r_z    [CORDIC_STEPS+1];

    assign fold = i_x[W-1];
    assign x0   = fold ? -i_x : i_x;
    assign y0   = fold ? -i_y : i_y;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= x0;
            r_y[0]    <= y0;
            r_zero[0] <= (y0 == '0);
            r_z[0]    <= !fold ? '0 : (i_y[W-1] ? -PI_Q16 : PI_Q16);
        end
    end

    for (genvar s = 1; s <= CORDIC_STEPS; s++) begin : g_step
        logic signed [W-1:0] xs;
        logic signed [W-1:0] ys;

        assign xs = r_x[s-1] >>> (s-1);
        assign ys = r_y[s-1] >>> (s-1);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_zero[s-1]) begin
                    r_z[s] <= r_z[s-1];
                end else if (!r_y[s-1][W-1]) begin
                    r_z[s] <= r_z[s-1] + ATAN_Q16[s-1];
                end else begin
                    r_z[s] <= r_z[s-1] - ATAN_Q16[s-1];
                end
            end
        end

        if (s < CORDIC_STEPS) begin : g_xy
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_zero[s] <= r_zero[s-1];
                    if (r_zero[s-1]) begin
                        r_x[s] <= r_x[s-1];
                        r_y[s] <= r_y[s-1];
                    end else if (!r_y[s-1][W-1]) begin
                        r_x[s] <= r_x[s-1] + ys;
                        r_y[s] <= r_y[s-1] - xs;
                    end else begin
                        r_x[s] <= r_x[s-1] - ys;
                        r_y[s] <= r_y[s-1] + xs;
                    end
                end
            end
        end
    end

    assign o_z = r_z[CORDIC_STEPS];

endmodule

FILE: src/two_link_arm_inverse_kinematics.sv
// Top level: two-link planar arm inverse kinematics, elbow branch with positive sine.
// Depends on tlaik_pkg, tlaik_div, tlaik_sqrt, tlaik_cordic.
//
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+------------------------------------------
//  target   | i_valid  | o_stall  | i_in  (target_x, target_y)
//  angles   | o_valid  | i_stall  | o_out (shoulder_angle, elbow_angle, out_of_reach)
//  config   | i_cfg_we | -        | i_cfg_idx, i_cfg_wdata
//
// One transfer per cycle while the output is not stalled; data passes through the bit-per-stage
// divider and square root and the 18-stage CORDIC chain.
// Synchronous active-low reset clears all valid bits and loads the link lengths.
// A stall on a valid output freezes the whole pipeline; nothing is dropped or repeated.
module two_link_arm_inverse_kinematics import tlaik_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_ik_in           i_in,
    output logic             o_valid,
    input  logic             i_stall,
    output t_ik_out          o_out,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [LEN_W-1:0] i_cfg_wdata
);

    localparam logic signed [33:0] SAT_HI = (34'sd1 <<< (DATA_WIDTH - 1)) - 34'sd1;
    localparam logic signed [33:0] SAT_LO = -(34'sd1 <<< (DATA_WIDTH - 1));
    localparam logic [DIV_W-1:0]   ONE_Q30 = 31'd1 << 30;
    localparam logic [60:0]        ONE_Q60 = 61'd1 << 60;

    logic en;

    logic [LEN_W-1:0] r_l1;
    logic [LEN_W-1:0] r_l2;

    // stage 1
    logic                      r_v1;
    logic signed [COORD_W-1:0] r1_x, r1_y;
    logic signed [31:0]        r1_xx, r1_yy;
    logic [29:0]               r1_l1s, r1_l2s, r1_l12;

    // stage 2
    logic [33:0]               num, mag;
    logic [DIV_W-1:0]          den;
    logic                      flag2;
    logic                      r_v2;
    logic [DIV_W-1:0]          r2_mag, r2_den;
    t_div_sb                   r2_sb;

    logic                      d_v;
    logic [DIV_W-1:0]          d_q;
    t_div_sb                   d_sb;

    // stage 3 / 4
    logic [DIV_W-1:0]          cmag;
    logic                      r_v3, r_v4;
    t_sqrt_sb                  r3_sb, r4_sb;
    logic signed [63:0]        sq64;
    logic [60:0]               r4_sq;
    logic [RAD_W-1:0]          rad;

    logic                      q_v;
    logic [SQRT_W-1:0]         q_root;
    t_sqrt_sb                  q_sb;

    // stage 5 / 6
    logic                      r_v5, r_v6, r5_flag, r6_flag;
    logic [45:0]               r5_l2s2;
    logic signed [47:0]        r5_l2c2;
    logic [SQRT_W-1:0]         r5_s2;
    logic signed [31:0]        r5_c2;
    logic signed [COORD_W-1:0] r5_x, r5_y;
    logic signed [LINK_W-1:0]  r6_lx, r6_ly;
    logic signed [TGT_W-1:0]   r6_tx, r6_ty;
    logic signed [ELB_CW-1:0]  r6_ex, r6_ey;

    logic signed [Z_W-1:0]     z_tgt, z_link, z_elb;
    logic                      r_cv [CORDIC_LAT];
    logic                      r_cf [CORDIC_LAT];

    // output stage
    logic signed [Z_W:0]       el_sum, el_q;
    logic signed [Z_W:0]       diff;
    logic signed [Z_W+1:0]     sh_sum, sh_q;
    logic signed [33:0]        sh34;
    logic [ELB_W-1:0]          el_fin;
    logic [ANG_W-1:0]          sh_fin;
    logic                      r_out_v;
    t_ik_out                   r_out;

    assign en      = !(r_out_v && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1 <= L1_RESET;
            r_l2 <= L2_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_UPPER_LINK: r_l1 <= i_cfg_wdata;
                REG_LOWER_LINK: r_l2 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= d_v;
            r_v4 <= r_v3;
            r_v5 <= q_v;
            r_v6 <= r_v5;
        end
    end

    // stage 1: squares and link product
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x   <= i_in.target_x;
            r1_y   <= i_in.target_y;
            r1_xx  <= i_in.target_x * i_in.target_x;
            r1_yy  <= i_in.target_y * i_in.target_y;
            r1_l1s <= r_l1 * r_l1;
            r1_l2s <= r_l2 * r_l2;
            r1_l12 <= r_l1 * r_l2;
        end
    end

    // stage 2: law of cosines numerator, denominator, reach check
    assign num   = {2'b00, r1_xx} + {2'b00, r1_yy} - {4'b0000, r1_l1s} - {4'b0000, r1_l2s};
    assign mag   = num[33] ? -num : num;
    assign den   = {r1_l12, 1'b0};
    assign flag2 = (den == '0) || (mag > {3'b000, den});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_mag     <= mag[DIV_W-1:0];
            r2_den     <= den;
            r2_sb.neg  <= num[33];
            r2_sb.flag <= flag2;
            r2_sb.x    <= r1_x;
            r2_sb.y    <= r1_y;
        end
    end

    tlaik_div #(
        .SB_W ($bits(t_div_sb))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v2),
        .i_mag   (r2_mag),
        .i_den   (r2_den),
        .i_sb    (r2_sb),
        .o_valid (d_v),
        .o_quo   (d_q),
        .o_sb    (d_sb)
    );

    // stage 3: signed, clamped c2
    assign cmag = d_sb.flag ? ONE_Q30 : d_q;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_sb.flag <= d_sb.flag;
            r3_sb.c2   <= d_sb.neg ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
            r3_sb.x    <= d_sb.x;
            r3_sb.y    <= d_sb.y;
        end
    end

    // stage 4: c2 squared
    assign sq64 = r3_sb.c2 * r3_sb.c2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sq <= sq64[60:0];
            r4_sb <= r3_sb;
        end
    end

    assign rad = {1'b0, ONE_Q60 - r4_sq};

    tlaik_sqrt #(
        .SB_W ($bits(t_sqrt_sb))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v4),
        .i_rad   (rad),
        .i_sb    (r4_sb),
        .o_valid (q_v),
        .o_root  (q_root),
        .o_sb    (q_sb)
    );

    // stage 5: link triangle products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_l2s2 <= r_l2 * q_root;
            r5_l2c2 <= $signed({1'b0, r_l2}) * q_sb.c2;
            r5_s2   <= q_root;
            r5_c2   <= q_sb.c2;
            r5_x    <= q_sb.x;
            r5_y    <= q_sb.y;
            r5_flag <= q_sb.flag;
        end
    end

    // stage 6: CORDIC operands
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_lx   <= $signed({5'b00000, r_l1, 30'b0}) + $signed({{2{r5_l2c2[47]}}, r5_l2c2});
            r6_ly   <= $signed({4'b0000, r5_l2s2});
            r6_tx   <= $signed({{2{r5_x[COORD_W-1]}}, r5_x, 30'b0});
            r6_ty   <= $signed({{2{r5_y[COORD_W-1]}}, r5_y, 30'b0});
            r6_ex   <= $signed({{2{r5_c2[31]}}, r5_c2});
            r6_ey   <= $signed({3'b000, r5_s2});
            r6_flag <= r5_flag;
        end
    end

    tlaik_cordic #(.W(TGT_W)) u_cordic_tgt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r6_tx),
        .i_y   (r6_ty),
        .o_z   (z_tgt)
    );

    tlaik_cordic #(.W(LINK_W)) u_cordic_link (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r6_lx),
        .i_y   (r6_ly),
        .o_z   (z_link)
    );

    tlaik_cordic #(.W(ELB_CW)) u_cordic_elb (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r6_ex),
        .i_y   (r6_ey),
        .o_z   (z_elb)
    );

    for (genvar k = 0; k < CORDIC_LAT; k++) begin : g_cdly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[k] <= 1'b0;
            end else if (en) begin
                r_cv[k] <= (k == 0) ? r_v6 : r_cv[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cf[k] <= (k == 0) ? r6_flag : r_cf[(k == 0) ? 0 : k-1];
            end
        end
    end

    // output stage: Q16 to Q3.12 rounding, clamps
    assign el_sum = $signed({z_elb[Z_W-1], z_elb}) + 21'sd8;
    assign el_q   = el_sum >>> 4;
    assign diff   = $signed({z_tgt[Z_W-1], z_tgt}) - $signed({z_link[Z_W-1], z_link});
    assign sh_sum = $signed({diff[Z_W], diff}) + 22'sd8;
    assign sh_q   = sh_sum >>> 4;

    always_comb begin
        sh34 = $signed({{(34-Z_W-2){sh_q[Z_W+1]}}, sh_q});
        if (sh34 > SAT_HI) begin
            sh34 = SAT_HI;
        end else if (sh34 < SAT_LO) begin
            sh34 = SAT_LO;
        end
        sh_fin = sh34[ANG_W-1:0];
        if (el_q < 0) begin
            el_fin = '0;
        end else if (el_q > $signed({7'b0, ELBOW_MAX})) begin
            el_fin = ELBOW_MAX;
        end else begin
            el_fin = el_q[ELB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_cv[CORDIC_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.shoulder_angle <= sh_fin;
            r_out.elbow_angle    <= el_fin;
            r_out.out_of_reach   <= r_cf[CORDIC_LAT-1];
        end
    end

    assign o_valid = r_out_v;
    assign o_out   = r_out;

    a_reach_elbow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.out_of_reach |->
            (o_out.elbow_angle == '0) || (o_out.elbow_angle == ELBOW_MAX))
        else $error("clamped reach must give a straight or folded elbow");

    a_elbow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out.elbow_angle <= ELBOW_MAX)
        else $error("elbow angle above pi");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_v1 && !r_v6)
        else $error("pipeline valid survives reset");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_v6) && $stable(r_cv[0]))
        else $error("pipeline moved while output stalled");

endmodule
